@@ design/ksb_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ksb_pkg: shared types and constants for the keyed sine tone burst
// Field widths, item codes and the small structs that pass between stages.
// ----------------------------------------------------------------------------
package ksb_pkg;

  localparam int MODE_W   = 2;
  localparam int KEY_W    = 4;
  localparam int CNT_W    = 13;
  localparam int FREQ_W   = 10;
  localparam int PROD_W   = CNT_W + FREQ_W;
  localparam int SAMPLE_W = 15;
  localparam int MAG_W    = 15;

  localparam logic [MODE_W-1:0] MODE_TICK  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_KEY   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

  localparam logic [CNT_W-1:0] BURST_RESET = 13'd6000;

  // largest positive sample; magnitudes above it clip on the positive side
  localparam logic [MAG_W-1:0] MAG_CLIP = 15'd16383;

  localparam int FIFO_DEPTH = 16;
  localparam int FIFO_AW    = 4;

  typedef struct packed {
    logic              valid;
    logic              done;
    logic [CNT_W-1:0]  count;
    logic [FREQ_W-1:0] freq;
  } tick_t;

  typedef struct packed {
    logic valid;
    logic done;
    logic neg;
  } tag_t;

endpackage
`default_nettype wire

@@ design/ksb_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ksb_if: channel interfaces of the keyed sine tone burst
// Item channel, result channel and burst length write channel.
// ----------------------------------------------------------------------------
interface ksb_item_if import ksb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [KEY_W-1:0]  key;

  modport source (output valid, output mode, output key, input ready);
  modport sink (input valid, input mode, input key, output ready);
endinterface

interface ksb_result_if import ksb_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       burst_done;

  modport source (output valid, output sample, output burst_done, input ready);
  modport sink (input valid, input sample, input burst_done, output ready);
endinterface

interface ksb_cfg_if import ksb_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] burst_length;

  modport source (output valid, output burst_length, input ready);
  modport sink (input valid, input burst_length, output ready);
endinterface
`default_nettype wire

@@ design/ksb_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ksb_ctrl: burst control state
// Holds count, done flag, keys and burst length; issues one tick per tick
// transaction into the phase pipeline.
// ----------------------------------------------------------------------------
module ksb_ctrl import ksb_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_acc,
  input  logic [MODE_W-1:0] mode,
  input  logic [KEY_W-1:0]  key,
  input  logic              cfg_wr,
  input  logic [CNT_W-1:0]  cfg_data,
  output tick_t             tick
);

  logic [CNT_W-1:0] burst_length;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             done_flag;
  logic             done_next;
  logic [KEY_W-1:0] current_key;
  logic [KEY_W-1:0] current_next;
  logic [KEY_W-1:0] latched_key;
  logic [KEY_W-1:0] latched_next;
  tick_t            tick_next;
  logic             acc_tick;

  function automatic logic [FREQ_W-1:0] note_freq(input logic [KEY_W-1:0] k);
    case (k)
      4'd1:    note_freq = 10'd262;
      4'd2:    note_freq = 10'd294;
      4'd3:    note_freq = 10'd330;
      4'd4:    note_freq = 10'd349;
      4'd5:    note_freq = 10'd392;
      4'd6:    note_freq = 10'd440;
      4'd7:    note_freq = 10'd494;
      4'd8:    note_freq = 10'd524;
      4'd9:    note_freq = 10'd588;
      default: note_freq = '0;
    endcase
  endfunction

  assign acc_tick = item_acc && (mode == MODE_TICK);

  always_comb begin
    count_next   = count;
    done_next    = done_flag;
    current_next = current_key;
    latched_next = latched_key;
    tick_next    = '0;
    if (item_acc) begin
      case (mode)
        MODE_TICK: begin
          tick_next.valid = 1'b1;
          if (count < burst_length) begin
            tick_next.done  = done_flag;
            tick_next.count = count;
            tick_next.freq  = note_freq(current_key);
            count_next      = count + CNT_W'(1);
          end else begin
            // end of burst: silence, zero frequency drives a zero sample
            tick_next.done = 1'b1;
            done_next      = 1'b1;
            latched_next   = current_key;
            count_next     = burst_length;
          end
        end
        MODE_KEY: begin
          current_next = key;
          if (done_flag && (latched_key != key)) begin
            count_next = '0;
            done_next  = 1'b0;
          end
        end
        MODE_CLEAR: begin
          count_next   = '0;
          done_next    = 1'b0;
          current_next = '0;
          latched_next = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      burst_length <= BURST_RESET;
      count        <= '0;
      done_flag    <= 1'b0;
      current_key  <= '0;
      latched_key  <= '0;
      tick         <= '0;
    end else begin
      if (cfg_wr) begin
        burst_length <= cfg_data;
      end
      count       <= count_next;
      done_flag   <= done_next;
      current_key <= current_next;
      latched_key <= latched_next;
      tick        <= tick_next;
    end
  end

  a_done_rise_on_tick: assert property (@(posedge clk) disable iff (rst)
    $rose(done_flag) |-> $past(acc_tick))
    else $error("done flag set without a tick transaction");

endmodule
`default_nettype wire

@@ design/ksb_phase.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ksb_phase: phase and quadrant pipeline
// count * freq, modulo by reciprocal multiply with one correction, then
// quadrant split and mirror into a sine table address.
// ----------------------------------------------------------------------------
module ksb_phase import ksb_pkg::*; #(
  parameter  int SAMPLE_RATE = 12000,
  localparam int SR_W        = $clog2(SAMPLE_RATE + 1)
) (
  input  logic            clk,
  input  logic            rst,
  input  tick_t           tick,
  output tag_t            tag,
  output logic [SR_W-1:0] addr
);

  localparam int RECIP   = (1 << PROD_W) / SAMPLE_RATE;
  localparam int RECIP_W = $clog2(RECIP + 1);
  localparam int EST_W   = PROD_W + RECIP_W;
  localparam int BACK_W  = RECIP_W + SR_W;
  localparam int Q_W     = SR_W + 2;

  localparam logic [SR_W:0]    SR_WIDE = (SR_W + 1)'(SAMPLE_RATE);
  localparam logic [SR_W-1:0]  SR_NARROW = SR_W'(SAMPLE_RATE);
  localparam logic [Q_W-1:0]   SR_Q1 = Q_W'(SAMPLE_RATE);
  localparam logic [Q_W-1:0]   SR_Q2 = Q_W'(2 * SAMPLE_RATE);
  localparam logic [Q_W-1:0]   SR_Q3 = Q_W'(3 * SAMPLE_RATE);

  tag_t               t2, t3, t4, t5;
  logic [PROD_W-1:0]  prod2;
  logic [PROD_W-1:0]  prod3;
  logic [RECIP_W-1:0] qe3;
  logic [SR_W:0]      rem4;
  logic [SR_W-1:0]    ph5;

  logic [EST_W-1:0]   est;
  logic [BACK_W-1:0]  back;
  logic [PROD_W-1:0]  diff;
  logic [Q_W-1:0]     q;
  logic [Q_W-1:0]     rq;
  logic [1:0]         quad;
  logic [SR_W-1:0]    r;
  logic [SR_W-1:0]    addr_next;

  assign est  = EST_W'(prod2) * EST_W'(RECIP);
  assign back = BACK_W'(qe3) * BACK_W'(SR_NARROW);
  assign diff = prod3 - PROD_W'(back);
  assign q    = {ph5, 2'b00};

  always_comb begin
    if (q >= SR_Q3) begin
      quad = 2'd3;
      rq   = q - SR_Q3;
    end else if (q >= SR_Q2) begin
      quad = 2'd2;
      rq   = q - SR_Q2;
    end else if (q >= SR_Q1) begin
      quad = 2'd1;
      rq   = q - SR_Q1;
    end else begin
      quad = 2'd0;
      rq   = q;
    end
    r = SR_W'(rq);
    addr_next = quad[0] ? SR_NARROW - r : r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      t2  <= '0;
      t3  <= '0;
      t4  <= '0;
      t5  <= '0;
      tag <= '0;
    end else begin
      t2  <= '{valid: tick.valid, done: tick.done, neg: 1'b0};
      t3  <= t2;
      t4  <= t3;
      t5  <= t4;
      tag <= '{valid: t5.valid, done: t5.done, neg: quad[1]};
    end
  end

  always_ff @(posedge clk) begin
    prod2 <= PROD_W'(tick.count) * PROD_W'(tick.freq);
    prod3 <= prod2;
    qe3   <= est[EST_W-1:PROD_W];
    rem4  <= diff[SR_W:0];
    ph5   <= (rem4 >= SR_WIDE) ? SR_W'(rem4 - SR_WIDE) : rem4[SR_W-1:0];
    addr  <= addr_next;
  end

  a_rem_one_correction: assert property (@(posedge clk) disable iff (rst)
    t4.valid |-> (rem4 < (SR_WIDE << 1)))
    else $error("reciprocal quotient estimate off by more than one");

  a_phase_in_range: assert property (@(posedge clk) disable iff (rst)
    t5.valid |-> (ph5 < SR_NARROW))
    else $error("phase not reduced below the sample rate");

endmodule
`default_nettype wire

@@ design/ksb_sine_rom.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ksb_sine_rom: quarter-wave sine magnitude table
// Synchronous ROM over the mirrored quadrant remainder, registered read.
// Contents built at elaboration with a Q30 Taylor series.
// ----------------------------------------------------------------------------
module ksb_sine_rom import ksb_pkg::*; #(
  parameter  int SAMPLE_RATE = 12000,
  parameter  int AMPLITUDE   = 10000,
  localparam int SR_W        = $clog2(SAMPLE_RATE + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  tag_t             tag_in,
  input  logic [SR_W-1:0]  addr,
  output tag_t             tag_out,
  output logic [MAG_W-1:0] mag
);

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic signed [63:0] Q30_ONE = 64'sd1073741824;
  localparam logic [63:0] MAG_LIMIT = 64'd16384;

  logic [MAG_W-1:0] rom [SAMPLE_RATE + 1];

  function automatic logic [MAG_W-1:0] sine_mag(input int unsigned rr);
    logic [63:0]        t;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic [63:0]        m;
    logic signed [63:0] sum;
    if (rr == 0) begin
      m = '0;
    end else if (rr >= SAMPLE_RATE) begin
      m = 64'(AMPLITUDE);
    end else begin
      t    = (64'(rr) << 30) / 64'(SAMPLE_RATE);
      x    = (t * HALF_PI_Q30) >> 30;
      x2   = (x * x) >> 30;
      sum  = $signed(x);
      term = ((x * x2) >> 30) / 6;
      sum  = sum - $signed(term);
      term = ((term * x2) >> 30) / 20;
      sum  = sum + $signed(term);
      term = ((term * x2) >> 30) / 42;
      sum  = sum - $signed(term);
      term = ((term * x2) >> 30) / 72;
      sum  = sum + $signed(term);
      term = ((term * x2) >> 30) / 110;
      sum  = sum - $signed(term);
      term = ((term * x2) >> 30) / 156;
      sum  = sum + $signed(term);
      term = ((term * x2) >> 30) / 210;
      sum  = sum - $signed(term);
      if (sum < 0) begin
        sum = '0;
      end
      if (sum > Q30_ONE) begin
        sum = Q30_ONE;
      end
      m = (64'(unsigned'(sum)) * 64'(AMPLITUDE)) >> 30;
    end
    if (m > MAG_LIMIT) begin
      m = MAG_LIMIT;
    end
    sine_mag = MAG_W'(m);
  endfunction

  for (genvar i = 0; i <= SAMPLE_RATE; i++) begin : g_rom
    localparam logic [MAG_W-1:0] ENTRY = sine_mag(i);
    assign rom[i] = ENTRY;
  end

  always_ff @(posedge clk) begin
    mag <= rom[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_out <= '0;
    end else begin
      tag_out <= tag_in;
    end
  end

endmodule
`default_nettype wire

@@ design/ksb_out_fifo.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ksb_out_fifo: result buffer and credit counter
// Formats the signed sample, buffers results, and limits ticks in flight so
// the buffer can never overflow.
// ----------------------------------------------------------------------------
module ksb_out_fifo import ksb_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       issue,
  input  tag_t                       tag,
  input  logic [MAG_W-1:0]           mag,
  output logic                       credit_ok,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] sample,
  output logic                       burst_done
);

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       done;
  } entry_t;

  localparam logic [FIFO_AW:0] DEPTH_W = (FIFO_AW + 1)'(FIFO_DEPTH);

  entry_t                     mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0]         wr_ptr;
  logic [FIFO_AW-1:0]         rd_ptr;
  logic [FIFO_AW:0]           fill;
  logic [FIFO_AW:0]           occ;
  logic                       wr;
  logic                       rd;
  logic signed [SAMPLE_W-1:0] fmt;

  assign wr        = tag.valid;
  assign out_valid = (fill != '0);
  assign rd        = out_valid && out_ready;
  assign credit_ok = (occ < DEPTH_W);
  assign sample     = mem[rd_ptr].sample;
  assign burst_done = mem[rd_ptr].done;

  always_comb begin
    if (tag.neg) begin
      fmt = SAMPLE_W'(-$signed({1'b0, mag}));
    end else if (mag > MAG_CLIP) begin
      fmt = MAG_CLIP;
    end else begin
      fmt = mag;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= '{sample: fmt, done: tag.done};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
      occ    <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= wr_ptr + FIFO_AW'(1);
      end
      if (rd) begin
        rd_ptr <= rd_ptr + FIFO_AW'(1);
      end
      fill <= fill + (FIFO_AW + 1)'(wr) - (FIFO_AW + 1)'(rd);
      occ  <= occ + (FIFO_AW + 1)'(issue) - (FIFO_AW + 1)'(rd);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    wr |-> ((fill < DEPTH_W) || rd))
    else $error("result buffer written while full");

  a_credit_covers_fill: assert property (@(posedge clk) disable iff (rst)
    fill <= occ)
    else $error("buffered results exceed ticks in flight");

endmodule
`default_nettype wire

@@ design/keyed_sine_tone_burst.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// keyed_sine_tone_burst: keypad-driven sine tone burst generator
//
// item   : one transaction per item; mode tick, key or clear, plus key code.
// result : one transaction per tick item, signed sample and burst_done flag,
//          in item order. Key and clear items give no result.
// cfg    : burst_length write; always ready; idle-only writes are the user's job.
// Path: an accepted tick passes the control tick register, five phase stages,
//   the sine ROM read and the result buffer before its result is offered.
// Throughput: one item per cycle while credit allows; control state loads at accept.
// Stall: up to 16 tick results may be in flight or buffered; while the
//   receiver holds ready low and 16 are outstanding, item.ready drops.
// Reset: count, done flag and keys clear, burst_length returns to 6000,
//   pipeline and buffer empty. The sine table is a ROM and needs no pass.
// ----------------------------------------------------------------------------
module keyed_sine_tone_burst import ksb_pkg::*; #(
  parameter int SAMPLE_RATE = 12000,
  parameter int AMPLITUDE   = 10000
) (
  input  logic   clk,
  input  logic   rst,
  ksb_item_if.sink     item,
  ksb_result_if.source result,
  ksb_cfg_if.sink      cfg
);

  localparam int SR_W = $clog2(SAMPLE_RATE + 1);

  logic             item_acc;
  logic             issue;
  logic             credit_ok;
  tick_t            tick;
  tag_t             phase_tag;
  logic [SR_W-1:0]  rom_addr;
  tag_t             rom_tag;
  logic [MAG_W-1:0] rom_mag;

  assign item.ready = credit_ok;
  assign cfg.ready  = 1'b1;
  assign item_acc   = item.valid && item.ready;
  assign issue      = item_acc && (item.mode == MODE_TICK);

  ksb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .item_acc (item_acc),
    .mode     (item.mode),
    .key      (item.key),
    .cfg_wr   (cfg.valid && cfg.ready),
    .cfg_data (cfg.burst_length),
    .tick     (tick)
  );

  ksb_phase #(
    .SAMPLE_RATE (SAMPLE_RATE)
  ) u_phase (
    .clk  (clk),
    .rst  (rst),
    .tick (tick),
    .tag  (phase_tag),
    .addr (rom_addr)
  );

  ksb_sine_rom #(
    .SAMPLE_RATE (SAMPLE_RATE),
    .AMPLITUDE   (AMPLITUDE)
  ) u_rom (
    .clk     (clk),
    .rst     (rst),
    .tag_in  (phase_tag),
    .addr    (rom_addr),
    .tag_out (rom_tag),
    .mag     (rom_mag)
  );

  ksb_out_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .issue      (issue),
    .tag        (rom_tag),
    .mag        (rom_mag),
    .credit_ok  (credit_ok),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .sample     (result.sample),
    .burst_done (result.burst_done)
  );

endmodule
`default_nettype wire
